// ----- rtl/positional_array_list_top_defines.svh -----
// Assertion macros shared by the positional array list RTL.
`ifndef POSITIONAL_ARRAY_LIST_TOP_DEFINES_SVH
`define POSITIONAL_ARRAY_LIST_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define PLAC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);
`define PLAC_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error(msg);
`else
`define PLAC_ASSERT(lbl, prop, msg)
`define PLAC_ASSERT_NEXT(lbl, trig, cond, msg)
`endif
`endif

// ----- rtl/plac_pkg.sv -----
// Shared types and constants for the positional array list.
package plac_pkg;

    localparam int DEF_MAX_ENTRIES = 16;
    localparam int DATA_W = 32;
    localparam int POS_W  = 5;
    localparam int OP_W   = 3;
    localparam int ST_W   = 3;
    localparam int CAP_W  = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
    localparam logic [OP_W-1:0] OP_GET    = 3'd2;
    localparam logic [OP_W-1:0] OP_UPDATE = 3'd3;
    localparam logic [OP_W-1:0] OP_FIND   = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

    localparam logic [ST_W-1:0] ST_OK        = 3'd0;
    localparam logic [ST_W-1:0] ST_FULL      = 3'd1;
    localparam logic [ST_W-1:0] ST_EMPTY     = 3'd2;
    localparam logic [ST_W-1:0] ST_INVALID   = 3'd3;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd4;

    typedef enum logic [2:0] {
        CELL_HOLD   = 3'd0,
        CELL_INSERT = 3'd1,
        CELL_REMOVE = 3'd2,
        CELL_WRITE  = 3'd3,
        CELL_ROTATE = 3'd4
    } t_cell_op;

    typedef struct packed {
        t_cell_op           op;
        logic [POS_W-1:0]   slot;
        logic [DATA_W-1:0]  value;
    } t_cell_cmd;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

endpackage

// ----- rtl/plac_cell.sv -----
// One list cell: holds one entry and moves it to or from its ring neighbors.
module plac_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic                        i_clk,
    input  plac_pkg::t_cell_cmd         i_cmd,
    input  logic [plac_pkg::DATA_W-1:0] i_left,
    input  logic [plac_pkg::DATA_W-1:0] i_right,
    output logic [plac_pkg::DATA_W-1:0] o_entry
);
    import plac_pkg::*;

    localparam logic [31:0] IDX = 32'(CELL_IDX);

    logic [DATA_W-1:0] r_entry;
    logic [31:0]       w_slot;

    assign w_slot  = 32'(i_cmd.slot);
    assign o_entry = r_entry;

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            CELL_INSERT: begin
                if (IDX == w_slot) begin
                    r_entry <= i_cmd.value;
                end else if (IDX > w_slot) begin
                    r_entry <= i_left;
                end
            end
            CELL_REMOVE: begin
                // close the gap: everything at or above the slot moves down
                if (IDX >= w_slot) begin
                    r_entry <= i_right;
                end
            end
            CELL_WRITE: begin
                if (IDX == w_slot) begin
                    r_entry <= i_cmd.value;
                end
            end
            CELL_ROTATE: begin
                r_entry <= i_right;
            end
            default: begin
                r_entry <= r_entry;
            end
        endcase
    end

endmodule

// ----- rtl/plac_chain.sv -----
// Ring of list cells; cell 0 is the head seen by the scan logic.
module plac_chain #(
    parameter int MAX_ENTRIES = plac_pkg::DEF_MAX_ENTRIES
) (
    input  logic                        i_clk,
    input  plac_pkg::t_cell_cmd         i_cmd,
    output logic [plac_pkg::DATA_W-1:0] o_head
);
    import plac_pkg::*;

    logic [DATA_W-1:0] w_entry [MAX_ENTRIES];

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        localparam int LEFT  = (g + MAX_ENTRIES - 1) % MAX_ENTRIES;
        localparam int RIGHT = (g + 1) % MAX_ENTRIES;
        plac_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (i_cmd),
            .i_left  (w_entry[LEFT]),
            .i_right (w_entry[RIGHT]),
            .o_entry (w_entry[g])
        );
    end

    assign o_head = w_entry[0];

endmodule

// ----- rtl/positional_array_list_top.sv -----
// Positional array list: ordered list of signed 32-bit values kept in a ring of cells.
// Insert, remove, update, clear, unused codes and any request that fails its checks
// are done in the cycle of acceptance and report in the next cycle, so they can
// run back to back. Get with a valid position and find rotate the cell ring once
// around through the head cell: busy stays high for the whole scan and the result
// beat is registered at the last scan step. Each result beat is on the ports for
// one cycle with o_done high and cannot be held off. The user must write the capacity
// register through i_cfg_we only while the block is idle; this is not enforced.
`include "positional_array_list_top_defines.svh"

module positional_array_list_top #(
    parameter int MAX_ENTRIES = plac_pkg::DEF_MAX_ENTRIES
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_cfg_we,
    input  logic        [plac_pkg::CAP_W-1:0]  i_cfg_wdata,
    input  logic        [plac_pkg::OP_W-1:0]   i_operation,
    input  logic        [plac_pkg::POS_W-1:0]  i_position,
    input  logic signed [plac_pkg::DATA_W-1:0] i_value,
    output logic                               o_done,
    output logic        [plac_pkg::ST_W-1:0]   o_status,
    output logic signed [plac_pkg::DATA_W-1:0] o_read_data,
    output logic        [plac_pkg::POS_W-1:0]  o_found_position,
    output logic        [plac_pkg::POS_W-1:0]  o_entry_count
);
    import plac_pkg::*;

    localparam int CW    = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = ((CW > POS_W) ? CW : POS_W) + 1;
    localparam int KW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam logic [KW-1:0]    K_LAST = KW'(MAX_ENTRIES - 1);
    localparam logic [CMP_W-1:0] MAXX   = CMP_W'(MAX_ENTRIES);

    t_state             r_state;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic [CAP_W-1:0]   r_cap;
    logic               r_done;
    logic               n_done;
    logic [KW-1:0]      r_k;

    logic               r_find;
    logic [DATA_W-1:0]  r_val;
    logic [POS_W-1:0]   r_slot;
    logic               r_hit;
    logic [DATA_W-1:0]  r_rd;
    logic [POS_W-1:0]   r_found;
    logic               n_hit;
    logic [DATA_W-1:0]  n_rd;
    logic [POS_W-1:0]   n_found;

    logic [ST_W-1:0]    r_status;
    logic [DATA_W-1:0]  r_rd_out;
    logic [POS_W-1:0]   r_found_out;
    logic [POS_W-1:0]   r_cnt_out;

    t_cell_cmd          w_cmd;
    logic [DATA_W-1:0]  w_head;
    logic               w_acc;
    logic               w_scan_go;
    logic               w_find;
    logic [ST_W-1:0]    w_status;
    logic [CMP_W-1:0]   w_posx;
    logic [CMP_W-1:0]   w_cntx;
    logic [CMP_W-1:0]   w_capx;
    logic [CMP_W-1:0]   w_kx;
    logic               w_pos_ok;
    logic               w_ins_pos_ok;
    logic               w_full;
    logic               w_match;
    logic               w_last;

    plac_chain #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_chain (
        .i_clk  (i_clk),
        .i_cmd  (w_cmd),
        .o_head (w_head)
    );

    assign busy  = (r_state == S_SCAN);
    assign w_acc = start && !busy;

    assign w_posx       = CMP_W'(i_position);
    assign w_cntx       = CMP_W'(r_count);
    assign w_capx       = CMP_W'(r_cap);
    assign w_pos_ok     = (i_position != '0) && (w_posx <= w_cntx);
    assign w_ins_pos_ok = (i_position != '0) && (w_posx <= w_cntx + 1'b1);
    assign w_full       = (w_cntx >= w_capx) || (w_cntx >= MAXX);

    // request decode in idle, ring rotation while scanning
    always_comb begin
        n_count    = r_count;
        w_cmd.op    = CELL_HOLD;
        w_cmd.slot  = i_position - 1'b1;
        w_cmd.value = i_value;
        w_status   = ST_OK;
        w_scan_go  = 1'b0;
        w_find     = 1'b0;
        if (busy) begin
            w_cmd.op = CELL_ROTATE;
        end else if (w_acc) begin
            case (i_operation)
                OP_INSERT: begin
                    if (w_full) begin
                        w_status = ST_FULL;
                    end else if (!w_ins_pos_ok) begin
                        w_status = ST_INVALID;
                    end else begin
                        w_cmd.op = CELL_INSERT;
                        n_count  = r_count + 1'b1;
                    end
                end
                OP_REMOVE: begin
                    if (r_count == '0) begin
                        w_status = ST_EMPTY;
                    end else if (!w_pos_ok) begin
                        w_status = ST_INVALID;
                    end else begin
                        w_cmd.op = CELL_REMOVE;
                        n_count  = r_count - 1'b1;
                    end
                end
                OP_GET: begin
                    if (!w_pos_ok) begin
                        w_status = ST_INVALID;
                    end else begin
                        w_scan_go = 1'b1;
                    end
                end
                OP_UPDATE: begin
                    if (!w_pos_ok) begin
                        w_status = ST_INVALID;
                    end else begin
                        w_cmd.op = CELL_WRITE;
                    end
                end
                OP_FIND: begin
                    w_scan_go = 1'b1;
                    w_find    = 1'b1;
                end
                OP_CLEAR: begin
                    n_count = '0;
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end
    end

    // head cell holds entry r_k during scan cycle r_k
    assign w_kx    = CMP_W'(r_k);
    assign w_last  = (r_k == K_LAST);
    assign w_match = r_find && !r_hit && (w_kx < w_cntx) && (w_head == r_val);
    assign n_hit   = r_hit || w_match;
    assign n_found = w_match ? POS_W'(w_kx + 1'b1) : r_found;
    assign n_rd    = (!r_find && (w_kx == CMP_W'(r_slot))) ? w_head : r_rd;

    // result beat after a request that needs no scan or at the end of a scan
    assign n_done  = ((r_state == S_IDLE) && w_acc && !w_scan_go) ||
                     ((r_state == S_SCAN) && w_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_cap   <= CAP_RESET;
            r_done  <= 1'b0;
            r_k     <= '0;
        end else begin
            r_done <= n_done;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_count <= n_count;
                        if (w_scan_go) begin
                            r_state <= S_SCAN;
                            r_k     <= '0;
                        end
                    end
                end
                S_SCAN: begin
                    if (w_last) begin
                        r_state <= S_IDLE;
                        r_k     <= '0;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // scan bookkeeping and result beat payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_SCAN) begin
            r_hit   <= n_hit;
            r_rd    <= n_rd;
            r_found <= n_found;
            if (w_last) begin
                r_status    <= (r_find && !n_hit) ? ST_NOT_FOUND : ST_OK;
                r_rd_out    <= r_find ? '0 : n_rd;
                r_found_out <= r_find ? n_found : '0;
                r_cnt_out   <= POS_W'(r_count);
            end
        end else if (w_acc) begin
            r_find  <= w_find;
            r_val   <= i_value;
            r_slot  <= i_position - 1'b1;
            r_hit   <= 1'b0;
            r_rd    <= '0;
            r_found <= '0;
            if (!w_scan_go) begin
                r_status    <= w_status;
                r_rd_out    <= '0;
                r_found_out <= '0;
                r_cnt_out   <= POS_W'(n_count);
            end
        end
    end

    assign o_done           = r_done;
    assign o_status         = r_status;
    assign o_read_data      = r_rd_out;
    assign o_found_position = r_found_out;
    assign o_entry_count    = r_cnt_out;

    `PLAC_ASSERT(a_state_onehot, $onehot(r_state), "state register not one-hot")
    `PLAC_ASSERT(a_count_bound, (CMP_W'(r_count) <= MAXX), "entry count above list size")
    `PLAC_ASSERT(a_done_idle, (o_done |-> !busy), "result beat while scan still running")
    `PLAC_ASSERT(a_k_idle, ((r_state == S_IDLE) |-> (r_k == '0)), "scan index not parked")
    `PLAC_ASSERT_NEXT(a_scan_start, w_acc && w_scan_go, busy, "scan did not start")

endmodule

// ----- bench/plac_list_checker.sv -----
// Scoreboard for the positional array list: predicts every result beat and compares it.
module plac_list_checker #(
    parameter int MAX_ENTRIES = plac_pkg::DEF_MAX_ENTRIES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  logic                        i_cfg_we,
    input  logic [plac_pkg::CAP_W-1:0]  i_cfg_wdata,
    input  logic [plac_pkg::OP_W-1:0]   i_operation,
    input  logic [plac_pkg::POS_W-1:0]  i_position,
    input  logic [plac_pkg::DATA_W-1:0] i_value,
    input  logic                        i_done,
    input  logic [plac_pkg::ST_W-1:0]   i_status,
    input  logic [plac_pkg::DATA_W-1:0] i_read_data,
    input  logic [plac_pkg::POS_W-1:0]  i_found_position,
    input  logic [plac_pkg::POS_W-1:0]  i_entry_count,
    output int                          o_fail_count,
    output int                          o_pending_beats,
    output logic [plac_pkg::POS_W-1:0]  o_list_count
);
    import plac_pkg::*;

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [DATA_W-1:0] read_data;
        logic [POS_W-1:0]  found;
        logic [POS_W-1:0]  entries;
    } t_list_beat;

    logic [DATA_W-1:0] list_mem [MAX_ENTRIES];
    int                list_len;
    logic [CAP_W-1:0]  cap_reg;
    t_list_beat        expected_q [$];

    function automatic t_list_beat apply_request(
        input logic [OP_W-1:0]   op,
        input logic [POS_W-1:0]  pos,
        input logic [DATA_W-1:0] val
    );
        t_list_beat beat;
        int         limit;
        int         p;
        int         idx;
        beat        = '0;
        beat.status = ST_OK;
        p           = int'(pos);
        // register values past the array size act as the array size
        limit = (int'(cap_reg) > MAX_ENTRIES) ? MAX_ENTRIES : int'(cap_reg);
        case (op)
            OP_INSERT: begin
                if (list_len >= limit || list_len >= MAX_ENTRIES) begin
                    beat.status = ST_FULL;
                end else if (p < 1 || p > list_len + 1) begin
                    beat.status = ST_INVALID;
                end else begin
                    for (idx = list_len; idx >= p; idx--)
                        list_mem[IW'(idx)] = list_mem[IW'(idx-1)];
                    list_mem[IW'(p-1)] = val;
                    list_len++;
                end
            end
            OP_REMOVE: begin
                if (list_len == 0) begin
                    beat.status = ST_EMPTY;
                end else if (p < 1 || p > list_len) begin
                    beat.status = ST_INVALID;
                end else begin
                    for (idx = p - 1; idx + 1 < list_len; idx++)
                        list_mem[IW'(idx)] = list_mem[IW'(idx+1)];
                    list_len--;
                end
            end
            OP_GET: begin
                if (p < 1 || p > list_len)
                    beat.status = ST_INVALID;
                else
                    beat.read_data = list_mem[IW'(p-1)];
            end
            OP_UPDATE: begin
                if (p < 1 || p > list_len)
                    beat.status = ST_INVALID;
                else
                    list_mem[IW'(p-1)] = val;
            end
            OP_FIND: begin
                beat.status = ST_NOT_FOUND;
                // keep the first hit only
                for (idx = 0; idx < list_len; idx++) begin
                    if (beat.found == '0 && list_mem[IW'(idx)] == val) begin
                        beat.found  = POS_W'(idx + 1);
                        beat.status = ST_OK;
                    end
                end
            end
            OP_CLEAR: list_len = 0;
            default: ;
        endcase
        beat.entries = POS_W'(list_len);
        return beat;
    endfunction

    task automatic compare_field(
        input string             field,
        input logic [DATA_W-1:0] want,
        input logic [DATA_W-1:0] got
    );
        if (want !== got) begin
            o_fail_count++;
            if (o_fail_count <= 100)
                $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                         $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_list_beat want;
        if (!i_rst_n) begin
            list_len = 0;
            cap_reg  = CAP_RESET;
            expected_q.delete();
        end else begin
            if (i_done) begin
                if (expected_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 100)
                        $display("%0t: extra beat: expected none, actual status %0d count %0d",
                                 $time, i_status, i_entry_count);
                end else begin
                    want = expected_q.pop_front();
                    compare_field("status", DATA_W'(want.status), DATA_W'(i_status));
                    compare_field("read_data", want.read_data, i_read_data);
                    compare_field("found_position", DATA_W'(want.found),
                                  DATA_W'(i_found_position));
                    compare_field("entry_count", DATA_W'(want.entries),
                                  DATA_W'(i_entry_count));
                end
            end
            if (i_cfg_we)
                cap_reg = i_cfg_wdata;
            if (start && !busy)
                expected_q.push_back(apply_request(i_operation, i_position, i_value));
        end
        o_pending_beats = expected_q.size();
        o_list_count    = POS_W'(list_len);
    end

endmodule

// ----- bench/tb_positional_array_list_top.sv -----
// Testbench top for the positional array list: drives requests and capacity writes, gives the verdict.
module tb_positional_array_list_top;
    import plac_pkg::*;

    localparam int              MAX_ENTRIES  = DEF_MAX_ENTRIES;
    localparam logic [OP_W-1:0] OP_SPARE_LO  = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI  = 3'd7;
    localparam int              RANDOM_ITEMS = 1950;
    localparam int              PHASES       = 10;
    localparam int              PW           = $clog2(PHASES - 1);
    localparam int              STALL_LIMIT  = 1000;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic                     i_cfg_we;
    logic        [CAP_W-1:0]  i_cfg_wdata;
    logic        [OP_W-1:0]   i_operation;
    logic        [POS_W-1:0]  i_position;
    logic signed [DATA_W-1:0] i_value;
    logic                     o_done;
    logic        [ST_W-1:0]   o_status;
    logic signed [DATA_W-1:0] o_read_data;
    logic        [POS_W-1:0]  o_found_position;
    logic        [POS_W-1:0]  o_entry_count;

    int                mismatch_count;
    int                beats_due;
    logic [POS_W-1:0]  model_count;
    int unsigned       quiet_cycles;
    logic [DATA_W-1:0] value_pool [8];
    logic [CAP_W-1:0]  phase_caps [PHASES-1] = '{5'd16, 5'd5, 5'd31, 5'd0, 5'd1,
                                                 5'd12, 5'd17, 5'd3, 5'd16};

    positional_array_list_top #(.MAX_ENTRIES(MAX_ENTRIES)) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_operation      (i_operation),
        .i_position       (i_position),
        .i_value          (i_value),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_read_data      (o_read_data),
        .o_found_position (o_found_position),
        .o_entry_count    (o_entry_count)
    );

    plac_list_checker #(.MAX_ENTRIES(MAX_ENTRIES)) list_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_operation      (i_operation),
        .i_position       (i_position),
        .i_value          (i_value),
        .i_done           (o_done),
        .i_status         (o_status),
        .i_read_data      (o_read_data),
        .i_found_position (o_found_position),
        .i_entry_count    (o_entry_count),
        .o_fail_count     (mismatch_count),
        .o_pending_beats  (beats_due),
        .o_list_count     (model_count)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // end the run if neither a request nor a result moves for too long
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // call at a falling edge; holds start until the request is taken
    task automatic issue(
        input logic [OP_W-1:0]   op,
        input logic [POS_W-1:0]  pos,
        input logic [DATA_W-1:0] val
    );
        start       = 1'b1;
        i_operation = op;
        i_position  = pos;
        i_value     = val;
        do
            @(posedge i_clk);
        while (busy);
    endtask

    task automatic request(
        input logic [OP_W-1:0]   op,
        input logic [POS_W-1:0]  pos,
        input logic [DATA_W-1:0] val
    );
        @(negedge i_clk);
        issue(op, pos, val);
    endtask

    task automatic pause_sender(input int unsigned cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            start = 1'b0;
        end
    endtask

    // drain every result before touching the register
    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        @(negedge i_clk);
        start = 1'b0;
        while (beats_due != 0 || busy)
            @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = cap;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        // a small pool gives find hits and duplicate entries
        if ($urandom_range(0, 1) == 0)
            return value_pool[3'($urandom_range(0, 7))];
        return $urandom;
    endfunction

    task automatic random_request();
        int unsigned      roll;
        int unsigned      cnt;
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] pos;
        @(negedge i_clk);
        cnt  = model_count;
        roll = $urandom_range(0, 99);
        if (roll < 34)
            op = OP_INSERT;
        else if (roll < 54)
            op = OP_REMOVE;
        else if (roll < 68)
            op = OP_GET;
        else if (roll < 78)
            op = OP_UPDATE;
        else if (roll < 93)
            op = OP_FIND;
        else if (roll < 96)
            op = OP_CLEAR;
        else
            op = roll[0] ? OP_SPARE_HI : OP_SPARE_LO;
        if ($urandom_range(0, 9) == 0 || (op != OP_INSERT && cnt == 0))
            pos = POS_W'($urandom_range(0, 31));
        else if (op == OP_INSERT)
            pos = POS_W'($urandom_range(1, cnt + 1));
        else
            pos = POS_W'($urandom_range(1, cnt));
        issue(op, pos, pick_value());
    endtask

    initial begin
        int unsigned sent;
        int unsigned burst;
        int          phase;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        i_operation = OP_INSERT;
        i_position  = '0;
        i_value     = '0;
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7fff_ffff;
        value_pool[2] = 32'hffff_ffff;
        value_pool[3] = 32'h0000_0000;
        for (int k = 4; k < 8; k++)
            value_pool[3'(k)] = $urandom;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        set_capacity(CAP_RESET);
        // empty list: remove says empty whatever the position, get is invalid, find misses
        request(OP_REMOVE, 5'd3, 32'd0);
        request(OP_GET, 5'd1, 32'd0);
        request(OP_FIND, 5'd0, 32'd0);
        request(OP_INSERT, 5'd0, 32'd9);
        request(OP_INSERT, 5'd2, 32'd9);
        request(OP_INSERT, 5'd1, 32'h8000_0000);
        request(OP_INSERT, 5'd2, 32'h7fff_ffff);
        request(OP_INSERT, 5'd1, 32'hffff_ffff);
        request(OP_INSERT, 5'd4, 32'h0000_0000);
        request(OP_INSERT, 5'd31, 32'd5);
        for (int k = 1; k <= 5; k++)
            request(OP_GET, POS_W'(k), 32'd0);
        request(OP_UPDATE, 5'd2, 32'h5555_5555);
        request(OP_UPDATE, 5'd0, 32'haaaa_aaaa);
        request(OP_FIND, 5'd0, 32'h7fff_ffff);
        request(OP_INSERT, 5'd2, 32'h0000_0000);
        request(OP_FIND, 5'd31, 32'h0000_0000);
        request(OP_FIND, 5'd0, 32'h1234_5678);
        request(OP_REMOVE, 5'd0, 32'd0);
        request(OP_REMOVE, 5'd5, 32'd0);
        request(OP_SPARE_LO, 5'd31, 32'hffff_ffff);
        request(OP_SPARE_HI, 5'd0, 32'd0);
        request(OP_CLEAR, 5'd7, 32'd0);

        // full takes priority over a bad position
        set_capacity(5'd2);
        request(OP_INSERT, 5'd1, 32'd11);
        request(OP_INSERT, 5'd1, 32'd22);
        request(OP_INSERT, 5'd9, 32'd33);
        set_capacity(5'd0);
        request(OP_INSERT, 5'd1, 32'd44);
        // capacity below the count keeps the entries
        set_capacity(5'd1);
        request(OP_INSERT, 5'd3, 32'd55);
        request(OP_GET, 5'd2, 32'd0);
        request(OP_CLEAR, 5'd0, 32'd0);

        for (phase = 0; phase < PHASES; phase++) begin
            if (phase < PHASES - 1)
                set_capacity(phase_caps[PW'(phase)]);
            else
                set_capacity(CAP_W'($urandom_range(0, 31)));
            sent = 0;
            while (sent < RANDOM_ITEMS / PHASES) begin
                burst = $urandom_range(1, 24);
                if (burst > RANDOM_ITEMS / PHASES - sent)
                    burst = RANDOM_ITEMS / PHASES - sent;
                repeat (burst) begin
                    random_request();
                    sent++;
                end
                if ($urandom_range(0, 3) != 0)
                    pause_sender($urandom_range(1, 9));
            end
        end

        @(negedge i_clk);
        start = 1'b0;
        while (beats_due != 0)
            @(negedge i_clk);
        repeat (MAX_ENTRIES + 2) @(posedge i_clk);
        if (mismatch_count == 0 && beats_due == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
